// ===== sv/clc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clc_pkg: shared types and constants of the card number classifier
// widths, state encoding, verdict codes and the doubled-digit table
// ----------------------------------------------------------------------------
package clc_pkg;

  localparam int CardW      = 54;                  // binary card number width
  localparam int BcdDigits  = 17;                  // 2^54 - 1 has 17 decimal digits
  localparam int BcdW       = 4 * BcdDigits;
  localparam int CntW       = $clog2(CardW);       // conversion and digit pass counter
  localparam int CountW     = 5;                   // digit_count width
  localparam int VerdictW   = 2;
  localparam int MaxDigits  = 16;                  // longest classifiable number

  localparam logic [VerdictW-1:0] VERDICT_INVALID = 2'd0;
  localparam logic [VerdictW-1:0] VERDICT_3437    = 2'd1;
  localparam logic [VerdictW-1:0] VERDICT_5155    = 2'd2;
  localparam logic [VerdictW-1:0] VERDICT_LEAD4   = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_DIGIT,
    ST_FIN
  } state_e;

  // digit sum of twice a decimal digit
  function automatic logic [3:0] dbl_digit(input logic [3:0] d);
    logic [4:0] dd;
    dd = {d, 1'b0};
    if (d >= 4'd5) begin
      return 4'(dd - 5'd9);
    end
    return dd[3:0];
  endfunction

endpackage

// ===== sv/clc_intf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clc_intf: valid/ready channels of the card number classifier
// input channel carries the card number, result channel the verdict
// ----------------------------------------------------------------------------
interface clc_card_if;
  logic                      valid;
  logic                      ready;
  logic [clc_pkg::CardW-1:0] card_number;

  modport source (output valid, output card_number, input ready);
  modport sink   (input valid, input card_number, output ready);
endinterface

interface clc_res_if;
  logic                         valid;
  logic                         ready;
  logic [clc_pkg::VerdictW-1:0] verdict;
  logic                         luhn_ok;
  logic [clc_pkg::CountW-1:0]   digit_count;

  modport source (output valid, output verdict, output luhn_ok, output digit_count,
                  input ready);
  modport sink   (input valid, input verdict, input luhn_ok, input digit_count,
                  output ready);
endinterface

// ===== sv/card_number_luhn_classifier.sv =====
`timescale 1ns / 1ps
// after an item is accepted: one conversion step per card number bit, one
//   digit step per bcd digit, then a classify step that loads the output
//   register once it is free; a new item is taken only back in idle, after
//   the serial binary-to-bcd shifter and the one-digit-per-cycle luhn pass
// reset: asynchronous active low, returns to idle with no result pending
// ----------------------------------------------------------------------------
// card_number_luhn_classifier: luhn mod-10 check and card class decode
// converts the binary card number to bcd one bit per cycle (shift and add 3),
// then walks the digits from the right one per cycle, accumulating the luhn
// sum modulo ten and tracking the digit count and leading digits
// ----------------------------------------------------------------------------
module card_number_luhn_classifier (
  input  logic              clk_i,
  input  logic              rst_ni,
  clc_card_if.sink          card_i,
  clc_res_if.source         res_o
);

  // control
  clc_pkg::state_e               state_q, state_d;
  logic [clc_pkg::CntW-1:0]      cnt_q, cnt_d;
  logic                          out_vld_q, out_vld_d;

  // datapath
  logic [clc_pkg::CardW-1:0]     bin_q, bin_d;     // binary shifter, msb first
  logic [clc_pkg::BcdW-1:0]      bcd_q, bcd_d;     // bcd accumulator / digit shifter
  logic [3:0]                    sum_q, sum_d;     // luhn sum modulo ten
  logic [3:0]                    prev_q, prev_d;   // digit seen on the previous step
  logic [3:0]                    lead1_q, lead1_d; // most significant nonzero digit
  logic [3:0]                    lead2_q, lead2_d; // digit just right of it
  logic [clc_pkg::CountW-1:0]    ndig_q, ndig_d;   // significant digit count

  // result register
  logic [clc_pkg::VerdictW-1:0]  verdict_q, verdict_d;
  logic                          ok_q, ok_d;
  logic [clc_pkg::CountW-1:0]    count_q, count_d;

  // helper values
  logic [clc_pkg::BcdW-1:0]      bcd_adj;
  logic [3:0]                    cur_dig;
  logic [3:0]                    contrib;
  logic [4:0]                    sum_raw;
  logic                          out_free;
  logic                          luhn_ok;
  logic [clc_pkg::VerdictW-1:0]  verdict;

  assign card_i.ready = (state_q == clc_pkg::ST_IDLE);
  assign out_free     = !out_vld_q || res_o.ready;

  // add 3 to every bcd digit that is 5 or more before the shift
  always_comb begin
    for (int k = 0; k < clc_pkg::BcdDigits; k++) begin
      if (bcd_q[4*k +: 4] >= 4'd5) begin
        bcd_adj[4*k +: 4] = bcd_q[4*k +: 4] + 4'd3;
      end else begin
        bcd_adj[4*k +: 4] = bcd_q[4*k +: 4];
      end
    end
  end

  // digit pass: every second digit from the right, starting with the second, contributes the doubled digit sum
  assign cur_dig = bcd_q[3:0];
  assign contrib = cnt_q[0] ? clc_pkg::dbl_digit(cur_dig) : cur_dig;
  assign sum_raw = {1'b0, sum_q} + {1'b0, contrib};

  // classification from the finished digit pass
  assign luhn_ok = (sum_q == 4'd0);
  always_comb begin
    verdict = clc_pkg::VERDICT_INVALID;
    if (luhn_ok && ndig_q <= clc_pkg::CountW'(clc_pkg::MaxDigits)) begin
      if (ndig_q == 5'd15 && lead1_q == 4'd3 && (lead2_q == 4'd4 || lead2_q == 4'd7)) begin
        verdict = clc_pkg::VERDICT_3437;
      end else if (ndig_q == 5'd16 && lead1_q == 4'd5 &&
                   lead2_q >= 4'd1 && lead2_q <= 4'd5) begin
        verdict = clc_pkg::VERDICT_5155;
      end else if ((ndig_q == 5'd13 || ndig_q == 5'd16) && lead1_q == 4'd4) begin
        verdict = clc_pkg::VERDICT_LEAD4;
      end
    end
  end

  // next state and datapath
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    out_vld_d = out_vld_q;
    bin_d     = bin_q;
    bcd_d     = bcd_q;
    sum_d     = sum_q;
    prev_d    = prev_q;
    lead1_d   = lead1_q;
    lead2_d   = lead2_q;
    ndig_d    = ndig_q;
    verdict_d = verdict_q;
    ok_d      = ok_q;
    count_d   = count_q;

    // result taken
    if (out_vld_q && res_o.ready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      clc_pkg::ST_IDLE: begin
        if (card_i.valid) begin
          bin_d   = card_i.card_number;
          bcd_d   = '0;
          cnt_d   = '0;
          state_d = clc_pkg::ST_CONV;
        end
      end
      clc_pkg::ST_CONV: begin
        // one binary bit per cycle into the bcd register
        bcd_d = {bcd_adj[clc_pkg::BcdW-2:0], bin_q[clc_pkg::CardW-1]};
        bin_d = {bin_q[clc_pkg::CardW-2:0], 1'b0};
        if (cnt_q == clc_pkg::CntW'(clc_pkg::CardW - 1)) begin
          cnt_d   = '0;
          sum_d   = '0;
          prev_d  = '0;
          lead1_d = '0;
          lead2_d = '0;
          ndig_d  = '0;
          state_d = clc_pkg::ST_DIGIT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      clc_pkg::ST_DIGIT: begin
        // one decimal digit per cycle, least significant first
        bcd_d  = {4'd0, bcd_q[clc_pkg::BcdW-1:4]};
        sum_d  = (sum_raw >= 5'd10) ? 4'(sum_raw - 5'd10) : sum_raw[3:0];
        prev_d = cur_dig;
        if (cur_dig != 4'd0) begin
          lead1_d = cur_dig;
          lead2_d = prev_q;
          ndig_d  = cnt_q[clc_pkg::CountW-1:0] + 1'b1;
        end
        if (cnt_q == clc_pkg::CntW'(clc_pkg::BcdDigits - 1)) begin
          state_d = clc_pkg::ST_FIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      clc_pkg::ST_FIN: begin
        // load the result register once it is free
        if (out_free) begin
          verdict_d = verdict;
          ok_d      = luhn_ok;
          count_d   = ndig_q;
          out_vld_d = 1'b1;
          state_d   = clc_pkg::ST_IDLE;
        end
      end
      default: state_d = clc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= clc_pkg::ST_IDLE;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q     <= bin_d;
    bcd_q     <= bcd_d;
    sum_q     <= sum_d;
    prev_q    <= prev_d;
    lead1_q   <= lead1_d;
    lead2_q   <= lead2_d;
    ndig_q    <= ndig_d;
    verdict_q <= verdict_d;
    ok_q      <= ok_d;
    count_q   <= count_d;
  end

  assign res_o.valid       = out_vld_q;
  assign res_o.verdict     = verdict_q;
  assign res_o.luhn_ok     = ok_q;
  assign res_o.digit_count = count_q;

  // a new result only appears after the classify step
  a_res_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q) == clc_pkg::ST_FIN)
    else $error("result valid without classify step");

  // a failed luhn check never carries a class
  a_fail_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !ok_q) |-> verdict_q == clc_pkg::VERDICT_INVALID)
    else $error("class given for luhn failure");

  // a class only comes with a matching length
  a_class_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && verdict_q != clc_pkg::VERDICT_INVALID) |->
      (count_q == 5'd13 || count_q == 5'd15 || count_q == 5'd16))
    else $error("class given for unmatched length");

  // the digit count never exceeds the number of bcd digits
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> count_q <= clc_pkg::CountW'(clc_pkg::BcdDigits))
    else $error("digit count out of range");

endmodule
